[design/envc_pkg.sv]
// Shared types and constants for the environmental sensor compensation block.
package envc_pkg;

  localparam int unsigned RawTW   = 20;
  localparam int unsigned RawPW   = 20;
  localparam int unsigned RawHW   = 16;
  localparam int unsigned HumW    = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;

  localparam logic [31:0] PressOfs   = 32'd64000;
  localparam logic [31:0] PressBase  = 32'd1048576;
  localparam logic [31:0] PressScale = 32'd3125;
  localparam logic [31:0] HumOfs     = 32'd76800;
  localparam logic [31:0] HumRound   = 32'd16384;
  localparam logic [31:0] HumBias    = 32'd2097152;
  localparam logic [31:0] HumRound2  = 32'd8192;
  localparam logic [31:0] HumMax     = 32'd419430400;
  localparam logic [31:0] Half15     = 32'd32768;
  localparam logic [31:0] TempRound  = 32'd128;

  typedef enum logic [CfgIdxW-1:0] {
    RegTemp     = 3'd0,
    RegPressLo  = 3'd1,
    RegPressHi  = 3'd2,
    RegPressHum = 3'd3,
    RegHum      = 3'd4
  } cfg_idx_e;

  // Arithmetic right shift on a 32-bit two's complement word.
  function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

[design/env_sensor_compensation.sv]
// Top level: pipelined 32-bit integer temperature, pressure and humidity compensation.
// Each accepted input item passes the front, divider and post stages to the output register.
// Throughput: one item per cycle while the output is not stalled; the 32-stage restoring
//   divider (one quotient bit a stage) sets the depth.
// Stall: all stages advance together when the output register is empty or taken.
// Reset: asynchronous, active low; clears the valid bits and all coefficient
//   registers to zero. No clearing pass is needed.
module env_sensor_compensation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [envc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [envc_pkg::CfgW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  input  logic [envc_pkg::InDataW-1:0]  s_axis_tdata,
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: temperature_centi[31:0], pressure_pa[63:32], humidity_percent[70:64], zero pad
  output logic [envc_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned FrontSt = 11;
  localparam int unsigned DivSt   = 32;
  localparam int unsigned PostSt  = 3;
  localparam int unsigned NumSt   = FrontSt + DivSt + PostSt;

  // ---------------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------------
  logic [47:0] temp_c_q;
  logic [63:0] plo_c_q, phi_c_q;
  logic [47:0] ph_c_q;
  logic [39:0] hum_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_c_q <= '0;
      plo_c_q  <= '0;
      phi_c_q  <= '0;
      ph_c_q   <= '0;
      hum_c_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        envc_pkg::RegTemp:     temp_c_q <= cfg_data_i[47:0];
        envc_pkg::RegPressLo:  plo_c_q  <= cfg_data_i;
        envc_pkg::RegPressHi:  phi_c_q  <= cfg_data_i;
        envc_pkg::RegPressHum: ph_c_q   <= cfg_data_i[47:0];
        envc_pkg::RegHum:      hum_c_q  <= cfg_data_i[39:0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Unpack the coefficients to 32-bit words, signed fields sign-extended.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_c_q[15:0]};
  assign t2 = {{16{temp_c_q[31]}}, temp_c_q[31:16]};
  assign t3 = {{16{temp_c_q[47]}}, temp_c_q[47:32]};
  assign p1 = {16'd0, plo_c_q[15:0]};
  assign p2 = {{16{plo_c_q[31]}}, plo_c_q[31:16]};
  assign p3 = {{16{plo_c_q[47]}}, plo_c_q[47:32]};
  assign p4 = {{16{plo_c_q[63]}}, plo_c_q[63:48]};
  assign p5 = {{16{phi_c_q[15]}}, phi_c_q[15:0]};
  assign p6 = {{16{phi_c_q[31]}}, phi_c_q[31:16]};
  assign p7 = {{16{phi_c_q[47]}}, phi_c_q[47:32]};
  assign p8 = {{16{phi_c_q[63]}}, phi_c_q[63:48]};
  assign p9 = {{16{ph_c_q[15]}}, ph_c_q[15:0]};
  assign h1 = {24'd0, ph_c_q[23:16]};
  assign h2 = {{16{ph_c_q[39]}}, ph_c_q[39:24]};
  assign h3 = {24'd0, ph_c_q[47:40]};
  assign h4 = {{16{hum_c_q[15]}}, hum_c_q[15:0]};
  assign h5 = {{16{hum_c_q[31]}}, hum_c_q[31:16]};
  assign h6 = {{24{hum_c_q[39]}}, hum_c_q[39:32]};

  // ---------------------------------------------------------------------------
  // Flow control: one global advance, valid bits travel with the data
  // ---------------------------------------------------------------------------
  logic [NumSt-1:0] vld_q;
  logic             adv;
  logic             in_acc;

  assign adv           = !vld_q[NumSt-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;
  assign m_axis_tvalid = vld_q[NumSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumSt-2:0], in_acc};
    end
  end

  logic [envc_pkg::RawTW-1:0] raw_t;
  logic [envc_pkg::RawPW-1:0] raw_p;
  logic [envc_pkg::RawHW-1:0] raw_h;
  assign raw_t = s_axis_tdata[19:0];
  assign raw_p = s_axis_tdata[39:20];
  assign raw_h = s_axis_tdata[55:40];

  // ---------------------------------------------------------------------------
  // Front stages: temperature, then the pressure and humidity terms
  // ---------------------------------------------------------------------------
  logic [31:0] s1_xa_q, s1_dt_q;
  logic [envc_pkg::RawPW-1:0] s1_p_q, s2_p_q, s3_p_q, s4_p_q, s5_p_q, s6_p_q, s7_p_q,
                              s8_p_q, s9_p_q;
  logic [envc_pkg::RawHW-1:0] s1_h_q, s2_h_q, s3_h_q, s4_h_q, s5_h_q, s6_h_q;
  logic [31:0] s2_m1_q, s2_dd_q;
  logic [31:0] s3_at_q, s3_m2_q;
  logic [31:0] s4_tf_q;
  logic [31:0] s5_temp_q, s5_pa_q, s5_ah_q;
  logic [31:0] s6_temp_q, s6_d_q, s6_ap5_q, s6_p2a_q, s6_ah5_q, s6_ah6_q, s6_ah3_q;
  logic [31:0] s7_temp_q, s7_b1_q, s7_p3d_q, s7_ap5_q, s7_p2a_q, s7_dh_q, s7_x_q, s7_y_q;
  logic [31:0] s8_temp_q, s8_b_q, s8_a2_q, s8_xy_q, s8_dh_q;
  logic [31:0] s9_temp_q, s9_b_q, s9_a3m_q, s9_bm_q, s9_dh_q;
  logic [31:0] s10_temp_q, s10_div_q, s10_num_q, s10_b2_q, s10_dh_q;
  logic [31:0] s11_temp_q, s11_ha_q, s11_n_q, s11_d_q;
  logic        s11_big_q;

  logic [31:0] t_raw, s5_tf5, s6_q, s7_hsum, s9_a3, s10_nd;

  assign t_raw   = {12'd0, raw_t};
  assign s5_tf5  = (s4_tf_q << 2) + s4_tf_q;
  assign s6_q    = envc_pkg::sra(s5_pa_q, 5'd2);
  assign s7_hsum = ({16'd0, s6_h_q} << 14) - (h4 << 20) - s6_ah5_q + envc_pkg::HumRound;
  assign s9_a3   = envc_pkg::Half15 + s8_a2_q;
  assign s10_nd  = (envc_pkg::PressBase - {12'd0, s9_p_q}) - envc_pkg::sra(s9_b_q, 5'd12);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: offsets of the raw temperature
      s1_xa_q <= (t_raw >> 3) - (t1 << 1);
      s1_dt_q <= (t_raw >> 4) - t1;
      s1_p_q  <= raw_p;
      s1_h_q  <= raw_h;
      // stage 2: first products
      s2_m1_q <= s1_xa_q * t2;
      s2_dd_q <= s1_dt_q * s1_dt_q;
      s2_p_q  <= s1_p_q;
      s2_h_q  <= s1_h_q;
      // stage 3
      s3_at_q <= envc_pkg::sra(s2_m1_q, 5'd11);
      s3_m2_q <= envc_pkg::sra(s2_dd_q, 5'd12) * t3;
      s3_p_q  <= s2_p_q;
      s3_h_q  <= s2_h_q;
      // stage 4: fine temperature
      s4_tf_q <= s3_at_q + envc_pkg::sra(s3_m2_q, 5'd14);
      s4_p_q  <= s3_p_q;
      s4_h_q  <= s3_h_q;
      // stage 5: temperature result and the offsets for pressure and humidity
      s5_temp_q <= envc_pkg::sra(s5_tf5 + envc_pkg::TempRound, 5'd8);
      s5_pa_q   <= envc_pkg::sra(s4_tf_q, 5'd1) - envc_pkg::PressOfs;
      s5_ah_q   <= s4_tf_q - envc_pkg::HumOfs;
      s5_p_q    <= s4_p_q;
      s5_h_q    <= s4_h_q;
      // stage 6: products on the offsets
      s6_temp_q <= s5_temp_q;
      s6_d_q    <= s6_q * s6_q;
      s6_ap5_q  <= s5_pa_q * p5;
      s6_p2a_q  <= p2 * s5_pa_q;
      s6_ah5_q  <= h5 * s5_ah_q;
      s6_ah6_q  <= s5_ah_q * h6;
      s6_ah3_q  <= s5_ah_q * h3;
      s6_p_q    <= s5_p_q;
      s6_h_q    <= s5_h_q;
      // stage 7
      s7_temp_q <= s6_temp_q;
      s7_b1_q   <= envc_pkg::sra(s6_d_q, 5'd11) * p6;
      s7_p3d_q  <= p3 * envc_pkg::sra(s6_d_q, 5'd13);
      s7_ap5_q  <= s6_ap5_q;
      s7_p2a_q  <= s6_p2a_q;
      s7_dh_q   <= envc_pkg::sra(s7_hsum, 5'd15);
      s7_x_q    <= envc_pkg::sra(s6_ah6_q, 5'd10);
      s7_y_q    <= envc_pkg::sra(s6_ah3_q, 5'd11) + envc_pkg::Half15;
      s7_p_q    <= s6_p_q;
      // stage 8
      s8_temp_q <= s7_temp_q;
      s8_b_q    <= envc_pkg::sra(s7_b1_q + (s7_ap5_q << 1), 5'd2) + (p4 << 16);
      s8_a2_q   <= envc_pkg::sra(envc_pkg::sra(s7_p3d_q, 5'd3)
                                 + envc_pkg::sra(s7_p2a_q, 5'd1), 5'd18);
      s8_xy_q   <= s7_x_q * s7_y_q;
      s8_dh_q   <= s7_dh_q;
      s8_p_q    <= s7_p_q;
      // stage 9
      s9_temp_q <= s8_temp_q;
      s9_b_q    <= s8_b_q;
      s9_a3m_q  <= s9_a3 * p1;
      s9_bm_q   <= (envc_pkg::sra(s8_xy_q, 5'd10) + envc_pkg::HumBias) * h2;
      s9_dh_q   <= s8_dh_q;
      s9_p_q    <= s8_p_q;
      // stage 10: divisor and scaled numerator
      s10_temp_q <= s9_temp_q;
      s10_div_q  <= envc_pkg::sra(s9_a3m_q, 5'd15);
      s10_num_q  <= s10_nd * envc_pkg::PressScale;
      s10_b2_q   <= envc_pkg::sra(s9_bm_q + envc_pkg::HumRound2, 5'd14);
      s10_dh_q   <= s9_dh_q;
      // stage 11: dividend select and humidity product
      s11_temp_q <= s10_temp_q;
      s11_ha_q   <= s10_dh_q * s10_b2_q;
      s11_big_q  <= s10_num_q[31];
      s11_n_q    <= s10_num_q[31] ? s10_num_q : (s10_num_q << 1);
      s11_d_q    <= s10_div_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic [31:0] dv_r_q    [DivSt];
  logic [31:0] dv_n_q    [DivSt];
  logic [31:0] dv_d_q    [DivSt];
  logic [31:0] dv_temp_q [DivSt];
  logic [31:0] dv_ha_q   [DivSt];
  logic        dv_big_q  [DivSt];

  for (genvar k = 0; k < DivSt; k++) begin : g_div
    logic [31:0] r_in, n_in, d_in, temp_in, ha_in;
    logic        big_in;
    logic [32:0] sh, diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in    = '0;
      assign n_in    = s11_n_q;
      assign d_in    = s11_d_q;
      assign temp_in = s11_temp_q;
      assign ha_in   = s11_ha_q;
      assign big_in  = s11_big_q;
    end else begin : g_next
      assign r_in    = dv_r_q[k-1];
      assign n_in    = dv_n_q[k-1];
      assign d_in    = dv_d_q[k-1];
      assign temp_in = dv_temp_q[k-1];
      assign ha_in   = dv_ha_q[k-1];
      assign big_in  = dv_big_q[k-1];
    end

    assign sh   = {r_in, n_in[31]};
    assign diff = sh - {1'b0, d_in};
    assign ge   = !diff[32];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_r_q[k]    <= ge ? diff[31:0] : sh[31:0];
        dv_n_q[k]    <= {n_in[30:0], ge};
        dv_d_q[k]    <= d_in;
        dv_temp_q[k] <= temp_in;
        dv_ha_q[k]   <= ha_in;
        dv_big_q[k]  <= big_in;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Post stages: pressure correction and humidity clamp
  // ---------------------------------------------------------------------------
  logic [31:0] quo, q3, hsq_in;
  logic [31:0] pp1_temp_q, pp1_q_q, pp1_q3sq_q, pp1_qp8_q, pp1_sq_q, pp1_ha_q;
  logic        pp1_zero_q, pp2_zero_q;
  logic [31:0] pp2_temp_q, pp2_q_q, pp2_p9d_q, pp2_qp8_q, pp2_m_q, pp2_ha_q;
  logic [31:0] out_temp_q, out_press_q;
  logic [envc_pkg::HumW-1:0] out_hum_q;
  logic [31:0] fin_corr, hum_a;
  logic [envc_pkg::HumW-1:0] hum_pct;

  assign quo    = dv_big_q[DivSt-1] ? {dv_n_q[DivSt-1][30:0], 1'b0} : dv_n_q[DivSt-1];
  assign q3     = quo >> 3;
  assign hsq_in = envc_pkg::sra(dv_ha_q[DivSt-1], 5'd15);

  assign fin_corr = envc_pkg::sra(envc_pkg::sra(pp2_p9d_q, 5'd12)
                                  + envc_pkg::sra(pp2_qp8_q, 5'd13) + p7, 5'd4);

  always_comb begin
    hum_a = pp2_ha_q - envc_pkg::sra(pp2_m_q, 5'd4);
    if (hum_a[31]) begin
      hum_a = '0;
    end
    if (hum_a > envc_pkg::HumMax) begin
      hum_a = envc_pkg::HumMax;
    end
    hum_pct = hum_a[28:22];  // divide by 2^22; clamp keeps it at or below 100
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp1_temp_q  <= dv_temp_q[DivSt-1];
      pp1_q_q     <= quo;
      pp1_zero_q  <= (dv_d_q[DivSt-1] == '0);
      pp1_q3sq_q  <= q3 * q3;
      pp1_qp8_q   <= (quo >> 2) * p8;
      pp1_sq_q    <= hsq_in * hsq_in;
      pp1_ha_q    <= dv_ha_q[DivSt-1];

      pp2_temp_q  <= pp1_temp_q;
      pp2_q_q     <= pp1_q_q;
      pp2_zero_q  <= pp1_zero_q;
      pp2_p9d_q   <= p9 * (pp1_q3sq_q >> 13);
      pp2_qp8_q   <= pp1_qp8_q;
      pp2_m_q     <= envc_pkg::sra(pp1_sq_q, 5'd7) * h1;
      pp2_ha_q    <= pp1_ha_q;

      out_temp_q  <= pp2_temp_q;
      out_press_q <= pp2_zero_q ? '0 : (pp2_q_q + fin_corr);
      out_hum_q   <= hum_pct;
    end
  end

  assign m_axis_tdata = {1'b0, out_hum_q, out_press_q, out_temp_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[70:64] <= 7'd100))
    else $error("humidity above 100 percent");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item missing from first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during stall");

endmodule

[tb/tb_env_sensor_compensation.sv]
// Testbench for the environmental sensor compensation pipeline: random readings and coefficients.
`timescale 1ns / 1ps

module tb_env_sensor_compensation;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned Drain      = 120;

  typedef struct packed {
    logic [31:0] temperature_centi;
    logic [31:0] pressure_pa;
    logic [6:0]  humidity_percent;
  } reading_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [envc_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [envc_pkg::CfgW-1:0] cfg_data_i;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  logic [envc_pkg::InDataW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // temperature_centi[31:0], pressure_pa[63:32], humidity_percent[70:64], zero pad
  logic [envc_pkg::OutDataW-1:0] m_axis_tdata;

  env_sensor_compensation dut (.*);

  // Coefficient shadow copies used by the predictor.
  logic [47:0] k_temp;
  logic [63:0] k_press_lo;
  logic [63:0] k_press_hi;
  logic [47:0] k_press_hum;
  logic [39:0] k_hum;

  logic [envc_pkg::InDataW-1:0] pending_readings[$];
  reading_t           expected_readings[$];
  bit  failed;
  bit  stream_idle;      // while set, both sides idle randomly
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] asr(logic [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Compute the compensated temperature, pressure and humidity for one reading.
  function automatic reading_t compensate(logic [envc_pkg::InDataW-1:0] raw);
    logic [31:0] adc_t, adc_p, adc_h;
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, d, tf, pr, hm;
    reading_t r;
    adc_t = {12'd0, raw[19:0]};
    adc_p = {12'd0, raw[39:20]};
    adc_h = {16'd0, raw[55:40]};
    t1 = {16'd0, k_temp[15:0]};
    t2 = sx16(k_temp[31:16]);
    t3 = sx16(k_temp[47:32]);
    p1 = {16'd0, k_press_lo[15:0]};
    p2 = sx16(k_press_lo[31:16]);
    p3 = sx16(k_press_lo[47:32]);
    p4 = sx16(k_press_lo[63:48]);
    p5 = sx16(k_press_hi[15:0]);
    p6 = sx16(k_press_hi[31:16]);
    p7 = sx16(k_press_hi[47:32]);
    p8 = sx16(k_press_hi[63:48]);
    p9 = sx16(k_press_hum[15:0]);
    h1 = {24'd0, k_press_hum[23:16]};
    h2 = sx16(k_press_hum[39:24]);
    h3 = {24'd0, k_press_hum[47:40]};
    h4 = sx16(k_hum[15:0]);
    h5 = sx16(k_hum[31:16]);
    h6 = {{24{k_hum[39]}}, k_hum[39:32]};

    // temperature
    a = asr(((adc_t >> 3) - (t1 << 1)) * t2, 11);
    d = (adc_t >> 4) - t1;
    b = asr(asr(d * d, 12) * t3, 14);
    tf = a + b;
    r.temperature_centi = asr(tf * 32'd5 + 32'd128, 8);

    // pressure
    a = asr(tf, 1) - 32'd64000;
    d = asr(a, 2) * asr(a, 2);
    b = asr(d, 11) * p6;
    b = b + ((a * p5) << 1);
    b = asr(b, 2) + (p4 << 16);
    a = asr(asr(p3 * asr(d, 13), 3) + asr(p2 * a, 1), 18);
    a = asr((32'd32768 + a) * p1, 15);
    if (a == 32'd0) begin
      pr = 32'd0;
    end else begin
      pr = ((32'd1048576 - adc_p) - asr(b, 12)) * 32'd3125;
      if (pr < 32'h8000_0000) pr = (pr << 1) / a;
      else pr = (pr / a) * 32'd2;
      d = ((pr >> 3) * (pr >> 3)) >> 13;
      a = asr(p9 * d, 12);
      b = asr((pr >> 2) * p8, 13);
      pr = pr + asr(a + b + p7, 4);
    end
    r.pressure_pa = pr;

    // humidity, clamped to 0..419430400 before scaling
    a = tf - 32'd76800;
    d = asr(((adc_h << 14) - (h4 << 20) - (h5 * a)) + 32'd16384, 15);
    b = asr(asr(asr(a * h6, 10) * (asr(a * h3, 11) + 32'd32768), 10) + 32'd2097152, 0);
    b = asr(b * h2 + 32'd8192, 14);
    a = d * b;
    d = asr(a, 15);
    a = a - asr(asr(d * d, 7) * h1, 4);
    if (a[31]) a = 32'd0;
    if (a > 32'd419430400) a = 32'd419430400;
    hm = (a >> 12) / 32'd1024;
    r.humidity_percent = hm[6:0];
    return r;
  endfunction

  // Driver: present pending readings, idle at random while stream_idle is set.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readings.push_back(compensate(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_readings.size() > 0 && !(stream_idle && $urandom_range(99) < 32)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_readings.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall the output at random, check each result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      quiet_cycles  <= 0;
    end else begin
      m_axis_tready <= !(stream_idle && $urandom_range(99) < 32);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          failed = 1'b1;
        end else begin
          reading_t e;
          e = expected_readings.pop_front();
          if (m_axis_tdata[31:0] !== e.temperature_centi) begin
            $display("%0t: temperature expected %0d actual %0d", $time,
                     $signed(e.temperature_centi), $signed(m_axis_tdata[31:0]));
            failed = 1'b1;
          end
          if (m_axis_tdata[63:32] !== e.pressure_pa) begin
            $display("%0t: pressure expected %0d actual %0d", $time,
                     e.pressure_pa, m_axis_tdata[63:32]);
            failed = 1'b1;
          end
          if (m_axis_tdata[70:64] !== e.humidity_percent) begin
            $display("%0t: humidity expected %0d actual %0d", $time,
                     e.humidity_percent, m_axis_tdata[70:64]);
            failed = 1'b1;
          end
        end
      end
      if (quiet_cycles > WatchLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Write one coefficient register and mirror it in the predictor.
  task automatic write_coeffs(envc_pkg::cfg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      envc_pkg::RegTemp:     k_temp      = value[47:0];
      envc_pkg::RegPressLo:  k_press_lo  = value;
      envc_pkg::RegPressHi:  k_press_hi  = value;
      envc_pkg::RegPressHum: k_press_hum = value[47:0];
      envc_pkg::RegHum:      k_hum       = value[39:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Typical calibration set, so most readings land in a sensible range.
  task automatic load_typical();
    write_coeffs(envc_pkg::RegTemp, {16'd50, 16'd26435, 16'd27504});
    write_coeffs(envc_pkg::RegPressLo, {16'd2855, 16'd3024, 16'hD5D0, 16'd36477});
    write_coeffs(envc_pkg::RegPressHi, {16'hC0DB, 16'd15500, 16'hFFF9, 16'd140});
    write_coeffs(envc_pkg::RegPressHum, {8'd0, 16'd366, 8'd75, 16'd6000});
    write_coeffs(envc_pkg::RegHum, {8'd30, 16'd50, 16'd320});
  endtask

  task automatic load_random();
    write_coeffs(envc_pkg::RegTemp, {$urandom, $urandom});
    write_coeffs(envc_pkg::RegPressLo, {$urandom, $urandom});
    write_coeffs(envc_pkg::RegPressHi, {$urandom, $urandom});
    write_coeffs(envc_pkg::RegPressHum, {$urandom, $urandom});
    write_coeffs(envc_pkg::RegHum, {$urandom, $urandom});
  endtask

  function automatic logic [envc_pkg::InDataW-1:0] pack_raw(logic [19:0] t, logic [19:0] p,
                                                            logic [15:0] h);
    return {h, p, t};
  endfunction

  // Random reading: mostly near the working point, sometimes across full range.
  function automatic logic [envc_pkg::InDataW-1:0] rand_raw();
    if ($urandom_range(3) == 0)
      return pack_raw(20'($urandom), 20'($urandom), 16'($urandom));
    return pack_raw(20'($urandom_range(560000, 470000)), 20'($urandom_range(450000, 250000)),
                    16'($urandom_range(40000, 20000)));
  endfunction

  // Hold until everything queued has come back, then let the pipe drain.
  task automatic wait_quiet();
    wait (pending_readings.size() == 0 && !s_axis_tvalid);
    wait (expected_readings.size() == 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    repeat (n) pending_readings.push_back(rand_raw());
  endtask

  initial begin
    failed = 1'b0;
    stream_idle = 1'b1;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    k_temp = '0;
    k_press_lo = '0;
    k_press_hi = '0;
    k_press_hum = '0;
    k_hum = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All coefficients zero after reset: zero divisor path.
    pending_readings.push_back(pack_raw(20'd0, 20'd0, 16'd0));
    pending_readings.push_back(pack_raw('1, '1, '1));
    wait_quiet();

    // Directed: field extremes under a typical calibration, plus a write
    // to an unused index, which must change nothing.
    load_typical();
    write_coeffs(envc_pkg::cfg_idx_e'(3'd7), '1);
    pending_readings.push_back(pack_raw(20'd0, 20'd0, 16'd0));
    pending_readings.push_back(pack_raw('1, '1, '1));
    pending_readings.push_back(pack_raw(20'h55555, 20'hAAAAA, 16'h5555));
    pending_readings.push_back(pack_raw(20'hAAAAA, 20'h55555, 16'hAAAA));
    pending_readings.push_back(pack_raw(20'd519888, 20'd415148, 16'd0));
    pending_readings.push_back(pack_raw(20'd519888, 20'd415148, 16'hFFFF));
    pending_readings.push_back(pack_raw(20'd519888, 20'd415148, 16'd30000));
    wait_quiet();

    // Extremes: every coefficient bit set, then the sign-bit-only pattern.
    write_coeffs(envc_pkg::RegTemp, '1);
    write_coeffs(envc_pkg::RegPressLo, '1);
    write_coeffs(envc_pkg::RegPressHi, '1);
    write_coeffs(envc_pkg::RegPressHum, '1);
    write_coeffs(envc_pkg::RegHum, '1);
    queue_random(6);
    wait_quiet();
    write_coeffs(envc_pkg::RegTemp, 64'h8000_8000_8000);
    write_coeffs(envc_pkg::RegPressLo, 64'h8000_8000_8000_8000);
    write_coeffs(envc_pkg::RegPressHi, 64'h8000_8000_8000_8000);
    write_coeffs(envc_pkg::RegPressHum, 64'h80_8000_80_8000);
    write_coeffs(envc_pkg::RegHum, 64'h80_8000_8000);
    queue_random(6);
    wait_quiet();

    // Random phase under the typical calibration, with a long no-idle stretch.
    load_typical();
    queue_random(300);
    wait_quiet();
    stream_idle = 1'b0;
    queue_random(150);
    wait_quiet();
    stream_idle = 1'b1;

    // Random calibrations: coefficients wrap freely here.
    repeat (8) begin
      load_random();
      queue_random(50);
      wait_quiet();
    end

    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
design/envc_pkg.sv
design/env_sensor_compensation.sv
tb/tb_env_sensor_compensation.sv
